// File: rtl/core/qssm_pkg.sv
`timescale 1ns / 1ps
package qssm_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int CNT_W    = 32;
    localparam int HALF_W   = 16;
    localparam int DRV_W    = 16;
    localparam int POS_W    = 48;
    localparam int DELTA_W  = 32;
    localparam int SPEED_W  = 32;
    localparam int TOTAL_W  = 40;
    localparam int GAIN_W   = 32;
    localparam int DZ_W     = 15;
    localparam int LIMIT_W  = 16;

    // Configuration port
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_INVERT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DZ     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 3'd4;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd2;

    // Reset values of the registers
    localparam logic              RST_INVERT = 1'b0;
    localparam logic              RST_WIDE   = 1'b1;
    localparam logic [GAIN_W-1:0] RST_GAIN   = '0;
    localparam logic [DZ_W-1:0]   RST_DZ     = '0;
    localparam logic [LIMIT_W-1:0] RST_LIMIT = 16'd250;

    localparam int WINDOW_TICKS_DEF = 25;

    // Stage loads for the speed pipeline
    typedef struct packed {
        logic ld_abs;
        logic ld_mul;
        logic ld_out;
    } t_spd_ctl;

endpackage

// File: rtl/core/qssm_ram.sv
`timescale 1ns / 1ps
module qssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 25,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/qssm_speed.sv
`timescale 1ns / 1ps
module qssm_speed (
    input  logic                                   i_clk,
    input  qssm_pkg::t_spd_ctl                     i_ctl,
    input  logic signed [qssm_pkg::TOTAL_W-1:0]    i_total,
    input  logic [qssm_pkg::GAIN_W-1:0]            i_gain,
    output logic signed [qssm_pkg::SPEED_W-1:0]    o_speed
);
    import qssm_pkg::*;

    localparam int LO_W  = 32;
    localparam int HI_W  = TOTAL_W - LO_W;
    localparam int PLO_W = LO_W + GAIN_W;
    localparam int PHI_W = HI_W + GAIN_W;
    localparam int Q_W   = PHI_W + 17;

    logic               r_neg_a;
    logic [TOTAL_W-1:0] r_mag;
    logic               r_neg_m;
    logic [PLO_W-1:0]   r_plo;
    logic [PHI_W-1:0]   r_phi;
    logic [Q_W-1:0]     q8;
    logic [SPEED_W-1:0] n_speed;

    // Magnitude of the window sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_abs) begin
            r_neg_a <= i_total[TOTAL_W-1];
            r_mag   <= i_total[TOTAL_W-1] ? (TOTAL_W'(0) - TOTAL_W'(i_total))
                                          : TOTAL_W'(i_total);
        end
    end

    // Split product: low 32 bits and high bits of the magnitude
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            r_neg_m <= r_neg_a;
            r_plo   <= PLO_W'(r_mag[LO_W-1:0]) * PLO_W'(i_gain);
            r_phi   <= PHI_W'(r_mag[TOTAL_W-1:LO_W]) * PHI_W'(i_gain);
        end
    end

    always_comb begin
        q8 = {1'b0, r_phi, 16'b0} + Q_W'(r_plo[PLO_W-1:16]);
        if (r_neg_m) begin
            if (q8 >= Q_W'(64'h8000_0000)) begin
                n_speed = 32'h8000_0000;
            end else begin
                n_speed = SPEED_W'(0) - q8[SPEED_W-1:0];
            end
        end else begin
            if (q8 > Q_W'(64'h7FFF_FFFF)) begin
                n_speed = 32'h7FFF_FFFF;
            end else begin
                n_speed = q8[SPEED_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_out) begin
            o_speed <= n_speed;
        end
    end

endmodule

// File: rtl/core/quadrature_speed_and_stall_monitor.sv
`timescale 1ns / 1ps
// Quadrature speed and stall monitor, one motor channel.
// Input channel: i_valid / o_stall with command, counter sample, enable and
// drive command. A transfer takes place at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall with position, step delta,
// Q8 speed and the feedback-ok flag, one result for every input transfer, in order.
// A result passes the input register, track update, magnitude, split multiply
// and result register, in that order, before it shows on o_valid.
// Throughput: one item per cycle while the output is not stalled; the track
// state (position, delta ring, window sum, stall counter) is updated as the
// item leaves the input register, and the delta ring RAM is read ahead at the next pointer.
// When the receiver stalls, results hold and the pipeline keeps accepting
// until every stage is full; o_stall then rises.
// Reset (synchronous, i_rst_n low) empties the pipeline, clears position,
// window, stall count and fault, and loads the register defaults. The ring
// contents are masked by per-entry valid bits, so no clearing pass is needed.
// Registers sit on the APB port at 4*index; pready is tied high.
module quadrature_speed_and_stall_monitor #(
    parameter int WINDOW_TICKS = qssm_pkg::WINDOW_TICKS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [qssm_pkg::CMD_W-1:0]            i_command,
    input  logic [qssm_pkg::CNT_W-1:0]            i_counter_value,
    input  logic                                  i_motor_enabled,
    input  logic signed [qssm_pkg::DRV_W-1:0]     i_drive_command,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [qssm_pkg::POS_W-1:0]     o_position,
    output logic signed [qssm_pkg::DELTA_W-1:0]   o_step_delta,
    output logic signed [qssm_pkg::SPEED_W-1:0]   o_speed_q8,
    output logic                                  o_feedback_ok,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [qssm_pkg::ADDR_W-1:0]           paddr,
    input  logic [qssm_pkg::DATA_W-1:0]           pwdata,
    output logic [qssm_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);
    import qssm_pkg::*;

    localparam int PTR_W = (WINDOW_TICKS > 1) ? $clog2(WINDOW_TICKS) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_TICKS - 1);

    typedef struct packed {
        logic signed [POS_W-1:0]   pos;
        logic signed [DELTA_W-1:0] step;
        logic                      ok;
    } t_side;

    // Configuration registers
    logic               r_invert;
    logic               r_wide;
    logic [GAIN_W-1:0]  r_gain;
    logic [DZ_W-1:0]    r_dz;
    logic [LIMIT_W-1:0] r_limit;
    logic               cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= RST_INVERT;
            r_wide   <= RST_WIDE;
            r_gain   <= RST_GAIN;
            r_dz     <= RST_DZ;
            r_limit  <= RST_LIMIT;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_INVERT: r_invert <= pwdata[0];
                REG_WIDE:   r_wide   <= pwdata[0];
                REG_GAIN:   r_gain   <= pwdata[GAIN_W-1:0];
                REG_DZ:     r_dz     <= pwdata[DZ_W-1:0];
                REG_LIMIT:  r_limit  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_INVERT: prdata = DATA_W'(r_invert);
            REG_WIDE:   prdata = DATA_W'(r_wide);
            REG_GAIN:   prdata = DATA_W'(r_gain);
            REG_DZ:     prdata = DATA_W'(r_dz);
            REG_LIMIT:  prdata = DATA_W'(r_limit);
            default:    prdata = '0;
        endcase
    end

    // Pipeline control: stage 0 input, 1 track, 2 magnitude, 3 multiply, 4 result
    logic [4:0] r_v;
    logic [4:0] adv;

    always_comb begin
        adv[4] = !r_v[4] || !i_stall;
        adv[3] = !r_v[3] || adv[4];
        adv[2] = !r_v[2] || adv[3];
        adv[1] = !r_v[1] || adv[2];
        adv[0] = !r_v[0] || adv[1];
    end

    assign o_stall = !adv[0];
    assign o_valid = r_v[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
            if (adv[4]) r_v[4] <= r_v[3];
        end
    end

    // Input register
    logic [CMD_W-1:0]        r_cmd;
    logic [CNT_W-1:0]        r_sample;
    logic                    r_en;
    logic signed [DRV_W-1:0] r_drive;

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_valid) begin
            r_cmd    <= i_command;
            r_sample <= i_counter_value;
            r_en     <= i_motor_enabled;
            r_drive  <= i_drive_command;
        end
    end

    // Track state
    logic [CNT_W-1:0]          r_prev;
    logic [POS_W-1:0]          r_pos;
    logic signed [TOTAL_W-1:0] r_total;
    logic [PTR_W-1:0]          r_ptr;
    logic [WINDOW_TICKS-1:0]   r_ring_ok;
    logic [LIMIT_W-1:0]        r_stall_cnt;
    logic                      r_fault;
    logic                      r_fwd;
    logic [DELTA_W-1:0]        r_fwd_data;

    logic                      fire;
    logic                      tick;
    logic [CNT_W-1:0]          sample;
    logic [CNT_W-1:0]          diff;
    logic [DELTA_W-1:0]        dext;
    logic [DELTA_W-1:0]        dbits;
    logic [DELTA_W-1:0]        ram_q;
    logic [DELTA_W-1:0]        old_delta;
    logic signed [DRV_W:0]     drv;
    logic signed [DRV_W:0]     dzp;
    logic                      commanded;
    logic [PTR_W-1:0]          n_ptr;
    logic [CNT_W-1:0]          n_prev;
    logic [POS_W-1:0]          n_pos;
    logic signed [TOTAL_W-1:0] n_total;
    logic [LIMIT_W-1:0]        n_stall_cnt;
    logic                      n_fault;
    logic                      ring_we;

    assign fire = r_v[0] && adv[1];
    assign tick = (r_cmd == CMD_TICK);
    assign ring_we = fire && tick;

    always_comb begin
        sample = r_wide ? r_sample : {{(CNT_W-HALF_W){1'b0}}, r_sample[HALF_W-1:0]};
        diff   = sample - r_prev;
        dext   = r_wide ? diff : {{(DELTA_W-HALF_W){diff[HALF_W-1]}}, diff[HALF_W-1:0]};
        dbits  = r_invert ? (DELTA_W'(0) - dext) : dext;

        old_delta = r_ring_ok[r_ptr] ? (r_fwd ? r_fwd_data : ram_q) : '0;

        drv = {r_drive[DRV_W-1], r_drive};
        dzp = {2'b00, r_dz};
        commanded = r_en && (drv > dzp || drv < -dzp);

        n_ptr       = r_ptr;
        n_prev      = r_prev;
        n_pos       = r_pos;
        n_total     = r_total;
        n_stall_cnt = r_stall_cnt;
        n_fault     = r_fault;

        case (r_cmd)
            CMD_TICK: begin
                n_ptr   = (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);
                n_prev  = sample;
                n_pos   = r_pos + {{(POS_W-DELTA_W){dbits[DELTA_W-1]}}, dbits};
                n_total = r_total
                        - {{(TOTAL_W-DELTA_W){old_delta[DELTA_W-1]}}, old_delta}
                        + {{(TOTAL_W-DELTA_W){dbits[DELTA_W-1]}}, dbits};
                if (commanded && dbits == '0) begin
                    n_stall_cnt = (r_stall_cnt < r_limit) ? r_stall_cnt + LIMIT_W'(1)
                                                           : r_stall_cnt;
                end else begin
                    n_stall_cnt = '0;
                end
                if (n_stall_cnt >= r_limit) n_fault = 1'b1;
            end
            CMD_CLEAR: begin
                n_stall_cnt = '0;
                n_fault     = 1'b0;
            end
            CMD_CAPTURE: begin
                n_prev = sample;
            end
            default: ;
        endcase

        // hold the pointer unless a tick leaves the input register
        if (!fire) n_ptr = r_ptr;
    end

    qssm_ram #(
        .WIDTH (DELTA_W),
        .DEPTH (WINDOW_TICKS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_ptr),
        .i_wdata (dbits),
        .i_raddr (n_ptr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_pos       <= '0;
            r_total     <= '0;
            r_ptr       <= '0;
            r_ring_ok   <= '0;
            r_stall_cnt <= '0;
            r_fault     <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            // write and read on the same entry: bypass the RAM's old data
            r_fwd <= ring_we && (n_ptr == r_ptr);
            if (fire) begin
                r_prev      <= n_prev;
                r_pos       <= n_pos;
                r_total     <= n_total;
                r_ptr       <= n_ptr;
                r_stall_cnt <= n_stall_cnt;
                r_fault     <= n_fault;
                if (tick) r_ring_ok[r_ptr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= dbits;
    end

    // Results travel beside the speed pipeline
    t_side                     r_s1;
    t_side                     r_s2;
    t_side                     r_s3;
    t_side                     r_s4;
    logic signed [TOTAL_W-1:0] r_s1_total;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s1.pos   <= n_pos;
            r_s1.step  <= tick ? dbits : '0;
            r_s1.ok    <= !n_fault;
            r_s1_total <= n_total;
        end
        if (adv[2]) r_s2 <= r_s1;
        if (adv[3]) r_s3 <= r_s2;
        if (adv[4]) r_s4 <= r_s3;
    end

    t_spd_ctl spd_ctl;

    assign spd_ctl.ld_abs = adv[2];
    assign spd_ctl.ld_mul = adv[3];
    assign spd_ctl.ld_out = adv[4];

    qssm_speed u_speed (
        .i_clk   (i_clk),
        .i_ctl   (spd_ctl),
        .i_total (r_s1_total),
        .i_gain  (r_gain),
        .o_speed (o_speed_q8)
    );

    assign o_position    = r_s4.pos;
    assign o_step_delta  = r_s4.step;
    assign o_feedback_ok = r_s4.ok;

endmodule

// File: rtl/core/qssm_checker.sv
`timescale 1ns / 1ps
module qssm_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_stall,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic signed [qssm_pkg::POS_W-1:0]     o_position,
    input logic signed [qssm_pkg::DELTA_W-1:0]   o_step_delta,
    input logic signed [qssm_pkg::SPEED_W-1:0]   o_speed_q8,
    input logic                                  o_feedback_ok
);
    import qssm_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // input side blocks only when every stage is full and the result is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with room in the pipeline");

    // a blocked input side cannot clear while the result stays stalled
    a_stall_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall ##1 i_stall |-> o_stall)
        else $error("input stall dropped while output held");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_position) && $stable(o_step_delta)
            && $stable(o_speed_q8) && $stable(o_feedback_ok))
        else $error("stalled result changed");

endmodule

bind quadrature_speed_and_stall_monitor qssm_checker u_qssm_checker (.*);
